/* rtl/rchs_pkg.sv */
// shared types, constants and helpers for the rotated cubic hooke stress block
package rchs_pkg;

   localparam int MAX_CRYSTALS = 64;
   localparam int DIMENSION    = 3;
   localparam bit IS_3D        = (DIMENSION >= 3);
   localparam int RAM_ADDR_W   = (MAX_CRYSTALS > 1) ? $clog2(MAX_CRYSTALS) : 1;
   localparam int CSR_ADDR_W   = 5;
   localparam int STAGES       = 12;

   localparam logic [2:0] REG_NORMAL = 3'd0;
   localparam logic [2:0] REG_SHEAR  = 3'd1;
   localparam logic [2:0] REG_CROSS  = 3'd2;
   localparam logic [2:0] REG_CUBIC  = 3'd3;
   localparam logic [2:0] REG_COUNT  = 3'd4;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef logic signed [31:0] word_type;
   typedef word_type [2:0] vec3_type;
   typedef word_type [2:0][2:0] mat_type;

   typedef struct packed {
      logic    load;
      logic    bad;
      logic    fa;
      logic    fc;
      mat_type e;
      mat_type r;
      mat_type s;
   } item_type;

   function automatic mat_type mask_dim(mat_type m);
      mat_type o;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            o[i][j] = ((i == 2 || j == 2) && !IS_3D) ? '0 : m[i][j];
         end
      end
      return o;
   endfunction

endpackage

/* rtl/rchs_if.sv */
// request and response channel interfaces
interface rchs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [5:0]  crystal_index;
   logic [1:0]  matrix_row;
   logic [1:0]  matrix_col;
   logic signed [31:0] rotation_entry;
   logic signed [31:0] strain_xx;
   logic signed [31:0] strain_yy;
   logic signed [31:0] strain_zz;
   logic signed [31:0] strain_xy;
   logic signed [31:0] strain_xz;
   logic signed [31:0] strain_yz;

   modport source (output valid, command, crystal_index, matrix_row, matrix_col,
                   rotation_entry, strain_xx, strain_yy, strain_zz, strain_xy,
                   strain_xz, strain_yz, input ready);
   modport sink (input valid, command, crystal_index, matrix_row, matrix_col,
                 rotation_entry, strain_xx, strain_yy, strain_zz, strain_xy,
                 strain_xz, strain_yz, output ready);
endinterface

interface rchs_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] stress_xx;
   logic signed [31:0] stress_yy;
   logic signed [31:0] stress_zz;
   logic signed [31:0] stress_xy;
   logic signed [31:0] stress_xz;
   logic signed [31:0] stress_yz;
   logic [1:0]  status;

   modport source (output valid, stress_xx, stress_yy, stress_zz, stress_xy,
                   stress_xz, stress_yz, status, input ready);
   modport sink (input valid, stress_xx, stress_yy, stress_zz, stress_xy,
                 stress_xz, stress_yz, status, output ready);
endinterface

/* rtl/rchs_ram.sv */
// generic single write, single registered read ram
module rchs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/rchs_lane.sv */
// one dot product lane: three products, rounding, sum and saturation
module rchs_lane (
   input  logic               clock,
   input  logic               en_prod,
   input  logic               en_sum,
   input  rchs_pkg::vec3_type a,
   input  rchs_pkg::vec3_type b,
   input  logic               half,
   output rchs_pkg::word_type sum_ff,
   output logic               sat_ff
);

   localparam logic signed [63:0] BIAS29 = 64'sd268435456;
   localparam logic signed [63:0] BIAS30 = 64'sd536870912;
   localparam logic signed [36:0] POS_MAX = 37'sd2147483647;
   localparam logic signed [36:0] NEG_MIN = -37'sd2147483648;

   logic signed [63:0] prod_ff [3];
   logic               half_ff;
   logic signed [63:0] w [3];
   logic signed [63:0] rnd [3];
   logic signed [36:0] acc;
   rchs_pkg::word_type sum_in;
   logic               sat_in;

   always_ff @(posedge clock) begin
      if (en_prod) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= $signed(a[k]) * $signed(b[k]);
         end
         half_ff <= half;
      end
      if (en_sum) begin
         sum_ff <= sum_in;
         sat_ff <= sat_in;
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         w[k]   = prod_ff[k] + (half_ff ? BIAS29 : BIAS30);
         rnd[k] = half_ff ? (w[k] >>> 29) : (w[k] >>> 30);
         acc    = acc + 37'(rnd[k]);
      end
      if (acc > POS_MAX) begin
         sum_in = 32'sh7fffffff;
         sat_in = 1'b1;
      end else if (acc < NEG_MIN) begin
         sum_in = 32'sh80000000;
         sat_in = 1'b1;
      end else begin
         sum_in = 32'(acc);
         sat_in = 1'b0;
      end
   end

endmodule

/* rtl/rotated_cubic_hooke_stress.sv */
// rotated cubic hooke law stress unit, twelve stage lane pipeline
// throughput: one beat per cycle while rsp.ready holds, through five multiplier lane groups of two registers each
// rotation table: nine rams of MAX_CRYSTALS words, one per matrix entry, registered read
// reset: synchronous, clears configuration registers and pipeline valids; table undefined until loaded
module rotated_cubic_hooke_stress (
   input  logic                                clock,
   input  logic                                reset,
   rchs_req_if.sink                            req,
   rchs_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rchs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
   localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

   rchs_pkg::word_type norm_ff, shear_ff, cross_ff;
   logic               cubic_ff;
   logic [6:0]         count_ff;

   logic [rchs_pkg::STAGES:1] v_ff;
   logic [rchs_pkg::STAGES:1] en;
   rchs_pkg::item_type item_ff [1:11];
   rchs_pkg::item_type item_in [1:11];

   rchs_pkg::word_type out_ff [6];
   logic [1:0]         status_ff;

   logic               acc;
   logic               idx_oob;
   logic               wr_ok;
   logic [2:0]         reg_idx;
   rchs_pkg::mat_type  ram_q, rm, t_mat, ep_mat, ep_sel, s_mat, u_mat, sig_mat;
   rchs_pkg::mat_type  e_raw;
   logic [8:0]         t_sat, u_sat;
   logic [5:0]         ep_sat, s_sat, sig_sat;
   logic               sig_flag;

   // configuration port
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff  <= '0;
         shear_ff <= '0;
         cross_ff <= '0;
         cubic_ff <= 1'b0;
         count_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            rchs_pkg::REG_NORMAL: norm_ff  <= pwdata;
            rchs_pkg::REG_SHEAR:  shear_ff <= pwdata;
            rchs_pkg::REG_CROSS:  cross_ff <= pwdata;
            rchs_pkg::REG_CUBIC:  cubic_ff <= pwdata[0];
            rchs_pkg::REG_COUNT:  count_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rchs_pkg::REG_NORMAL: prdata = norm_ff;
         rchs_pkg::REG_SHEAR:  prdata = shear_ff;
         rchs_pkg::REG_CROSS:  prdata = cross_ff;
         rchs_pkg::REG_CUBIC:  prdata = {31'd0, cubic_ff};
         rchs_pkg::REG_COUNT:  prdata = {25'd0, count_ff};
         default:              prdata = '0;
      endcase
   end

   // stage enables, a stage loads when empty or when the next one moves
   always_comb begin
      en[rchs_pkg::STAGES] = !v_ff[rchs_pkg::STAGES] || rsp.ready;
      for (int k = rchs_pkg::STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req.ready = en[1];
   assign acc       = req.valid && en[1];
   assign idx_oob   = 32'(req.crystal_index) >= rchs_pkg::MAX_CRYSTALS;
   assign wr_ok     = acc && (req.command == rchs_pkg::CMD_LOAD) && !idx_oob
                      && (req.matrix_row != 2'd3) && (req.matrix_col != 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req.valid;
         end
         for (int k = 2; k <= rchs_pkg::STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // rotation table
   for (genvar i = 0; i < 3; i++) begin : g_ram_row
      for (genvar j = 0; j < 3; j++) begin : g_ram_col
         rchs_ram #(.WIDTH(32), .DEPTH(rchs_pkg::MAX_CRYSTALS)) u_ram (
            .clock      (clock),
            .wr_en      (wr_ok && (req.matrix_row == 2'(i)) && (req.matrix_col == 2'(j))),
            .wr_addr    (rchs_pkg::RAM_ADDR_W'(req.crystal_index)),
            .wr_data    (req.rotation_entry),
            .rd_en      (en[1]),
            .rd_addr    (rchs_pkg::RAM_ADDR_W'(req.crystal_index)),
            .rd_data_ff (ram_q[i][j])
         );
      end
   end

   assign rm = rchs_pkg::mask_dim(ram_q);

   always_comb begin
      e_raw[0][0] = req.strain_xx;
      e_raw[1][1] = req.strain_yy;
      e_raw[2][2] = req.strain_zz;
      e_raw[0][1] = req.strain_xy;
      e_raw[1][0] = req.strain_xy;
      e_raw[0][2] = req.strain_xz;
      e_raw[2][0] = req.strain_xz;
      e_raw[1][2] = req.strain_yz;
      e_raw[2][1] = req.strain_yz;
   end

   // item pipeline
   always_comb begin
      item_in[1].load = (req.command == rchs_pkg::CMD_LOAD);
      item_in[1].bad  = (req.command == rchs_pkg::CMD_LOAD) ? idx_oob
                        : (cubic_ff && (idx_oob || ({1'b0, req.crystal_index} >= count_ff)));
      item_in[1].fa   = 1'b0;
      item_in[1].fc   = 1'b0;
      item_in[1].e    = rchs_pkg::mask_dim(e_raw);
      item_in[1].r    = '0;
      item_in[1].s    = '0;
      for (int k = 2; k <= 11; k++) begin
         item_in[k] = item_ff[k-1];
      end
      item_in[2].r  = rm;
      item_in[4].fa = item_ff[3].fa || (|t_sat);
      item_in[6].fa = item_ff[5].fa || (|ep_sat);
      item_in[8].fc = item_ff[7].fc || (|s_sat[4:0]) || (s_sat[5] && rchs_pkg::IS_3D);
      item_in[8].s  = s_mat;
      item_in[10].fa = item_ff[9].fa || (|u_sat);
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= 11; k++) begin
         if (en[k]) begin
            item_ff[k] <= item_in[k];
         end
      end
   end

   // t = eps r
   for (genvar i = 0; i < 3; i++) begin : g_t_row
      for (genvar j = 0; j < 3; j++) begin : g_t_col
         rchs_lane u_lane (
            .clock   (clock),
            .en_prod (en[2]),
            .en_sum  (en[3]),
            .a       (item_ff[1].e[i]),
            .b       ({rm[2][j], rm[1][j], rm[0][j]}),
            .half    (1'b0),
            .sum_ff  (t_mat[i][j]),
            .sat_ff  (t_sat[i*3+j])
         );
      end
   end

   // ep = r^T t, upper triangle
   for (genvar p = 0; p < 6; p++) begin : g_ep
      rchs_lane u_lane (
         .clock   (clock),
         .en_prod (en[4]),
         .en_sum  (en[5]),
         .a       ({item_ff[3].r[2][PAIR_I[p]], item_ff[3].r[1][PAIR_I[p]],
                    item_ff[3].r[0][PAIR_I[p]]}),
         .b       ({t_mat[2][PAIR_J[p]], t_mat[1][PAIR_J[p]], t_mat[0][PAIR_J[p]]}),
         .half    (1'b0),
         .sum_ff  (ep_mat[PAIR_I[p]][PAIR_J[p]]),
         .sat_ff  (ep_sat[p])
      );
      if (PAIR_I[p] != PAIR_J[p]) begin : g_mirror
         assign ep_mat[PAIR_J[p]][PAIR_I[p]] = ep_mat[PAIR_I[p]][PAIR_J[p]];
      end
   end

   assign ep_sel = cubic_ff ? ep_mat : item_ff[5].e;

   // s = c0 : ep
   for (genvar p = 0; p < 6; p++) begin : g_s
      if (PAIR_I[p] == PAIR_J[p]) begin : g_diag
         rchs_lane u_lane (
            .clock   (clock),
            .en_prod (en[6]),
            .en_sum  (en[7]),
            .a       ({cross_ff, cross_ff, norm_ff}),
            .b       ({ep_sel[(PAIR_I[p]+2)%3][(PAIR_I[p]+2)%3],
                       ep_sel[(PAIR_I[p]+1)%3][(PAIR_I[p]+1)%3],
                       ep_sel[PAIR_I[p]][PAIR_I[p]]}),
            .half    (1'b0),
            .sum_ff  (s_mat[PAIR_I[p]][PAIR_J[p]]),
            .sat_ff  (s_sat[p])
         );
      end else begin : g_shear
         rchs_lane u_lane (
            .clock   (clock),
            .en_prod (en[6]),
            .en_sum  (en[7]),
            .a       ({32'sd0, 32'sd0, shear_ff}),
            .b       ({32'sd0, 32'sd0, ep_sel[PAIR_I[p]][PAIR_J[p]]}),
            .half    (1'b1),
            .sum_ff  (s_mat[PAIR_I[p]][PAIR_J[p]]),
            .sat_ff  (s_sat[p])
         );
         assign s_mat[PAIR_J[p]][PAIR_I[p]] = s_mat[PAIR_I[p]][PAIR_J[p]];
      end
   end

   // u = s r^T
   for (genvar i = 0; i < 3; i++) begin : g_u_row
      for (genvar j = 0; j < 3; j++) begin : g_u_col
         rchs_lane u_lane (
            .clock   (clock),
            .en_prod (en[8]),
            .en_sum  (en[9]),
            .a       (item_ff[7].s == item_ff[7].s ? s_mat[i] : s_mat[i]),
            .b       (item_ff[7].r[j]),
            .half    (1'b0),
            .sum_ff  (u_mat[i][j]),
            .sat_ff  (u_sat[i*3+j])
         );
      end
   end

   // sig = r u, upper triangle
   for (genvar p = 0; p < 6; p++) begin : g_sig
      rchs_lane u_lane (
         .clock   (clock),
         .en_prod (en[10]),
         .en_sum  (en[11]),
         .a       (item_ff[9].r[PAIR_I[p]]),
         .b       ({u_mat[2][PAIR_J[p]], u_mat[1][PAIR_J[p]], u_mat[0][PAIR_J[p]]}),
         .half    (1'b0),
         .sum_ff  (sig_mat[PAIR_I[p]][PAIR_J[p]]),
         .sat_ff  (sig_sat[p])
      );
      if (PAIR_I[p] != PAIR_J[p]) begin : g_mirror
         assign sig_mat[PAIR_J[p]][PAIR_I[p]] = sig_mat[PAIR_I[p]][PAIR_J[p]];
      end
   end

   assign sig_flag = item_ff[11].fc || (cubic_ff && (item_ff[11].fa || (|sig_sat)));

   // merge and output register
   always_ff @(posedge clock) begin
      if (en[rchs_pkg::STAGES]) begin
         for (int p = 0; p < 6; p++) begin
            if (item_ff[11].load || item_ff[11].bad) begin
               out_ff[p] <= '0;
            end else if (!rchs_pkg::IS_3D && (PAIR_I[p] == 2 || PAIR_J[p] == 2)) begin
               out_ff[p] <= '0;
            end else if (cubic_ff) begin
               out_ff[p] <= sig_mat[PAIR_I[p]][PAIR_J[p]];
            end else begin
               out_ff[p] <= item_ff[11].s[PAIR_I[p]][PAIR_J[p]];
            end
         end
         if (item_ff[11].bad) begin
            status_ff <= rchs_pkg::STATUS_RANGE;
         end else if (item_ff[11].load) begin
            status_ff <= rchs_pkg::STATUS_OK;
         end else begin
            status_ff <= sig_flag ? rchs_pkg::STATUS_SAT : rchs_pkg::STATUS_OK;
         end
      end
   end

   assign rsp.valid     = v_ff[rchs_pkg::STAGES];
   assign rsp.stress_xx = out_ff[0];
   assign rsp.stress_xy = out_ff[1];
   assign rsp.stress_xz = out_ff[2];
   assign rsp.stress_yy = out_ff[3];
   assign rsp.stress_yz = out_ff[4];
   assign rsp.stress_zz = out_ff[5];
   assign rsp.status    = status_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v_ff[1])
      else $error("accepted beat did not enter the pipeline");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == rchs_pkg::STATUS_RANGE |->
         rsp.stress_xx == 0 && rsp.stress_yy == 0 && rsp.stress_zz == 0 &&
         rsp.stress_xy == 0 && rsp.stress_xz == 0 && rsp.stress_yz == 0)
      else $error("range error beat carries nonzero stress");

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rchs_pkg::IS_3D |->
         rsp.stress_zz == 0 && rsp.stress_xz == 0 && rsp.stress_yz == 0)
      else $error("out of plane stress in two dimensional build");

endmodule
